// ===== sv/rcc_pkg.sv =====
// ----------------------------------------------------------------------------
// rcc_pkg
// Shared types, codes and discriminant coefficients for the reflectance
// color classifier.
// ----------------------------------------------------------------------------
package rcc_pkg;

  localparam int COEF_W     = 24;  // signed Q16 coefficient width
  localparam int COEF_FRAC  = 16;  // coefficient fraction bits
  localparam int CHUNK_BITS = 17;  // ratio magnitude slice per multiply
  localparam int OP_W       = 18;  // signed multiplier operand width
  localparam int SHIFT_W    = 6;   // product alignment shift width
  localparam int ROWS       = 5;   // number of discriminants
  localparam int ROW_W      = 3;

  // ratio used when the green delta is zero (integer part)
  localparam int RATIO_ZERO_DEN = 10;

  // discriminant rows
  localparam logic [ROW_W-1:0] ROW_DEEP_WALL = 3'd0;
  localparam logic [ROW_W-1:0] ROW_GREEN     = 3'd1;
  localparam logic [ROW_W-1:0] ROW_PINK      = 3'd2;
  localparam logic [ROW_W-1:0] ROW_RED       = 3'd3;
  localparam logic [ROW_W-1:0] ROW_TALL_WALL = 3'd4;

  // term order inside one discriminant; ratio slices start at TERM_RATIO
  localparam int TERM_INIT  = 0;
  localparam int TERM_DIFF  = 1;
  localparam int TERM_SUM   = 2;
  localparam int TERM_RATIO = 3;

  // result classes
  localparam logic [1:0] CLASS_WALL  = 2'd0;
  localparam logic [1:0] CLASS_GREEN = 2'd1;
  localparam logic [1:0] CLASS_PINK  = 2'd2;
  localparam logic [1:0] CLASS_RED   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_MAC,
    ST_DRAIN,
    ST_STORE,
    ST_DECIDE
  } rcc_state_t;

  typedef struct packed {
    logic               clear;  // load accumulator with init value
    logic               issue;  // accumulate this cycle's coef * operand product
    logic [SHIFT_W-1:0] shamt;  // left alignment of the product
  } rcc_mac_ctrl_t;

  // Q16 coefficients, decimal value rounded to nearest
  localparam longint B0 = -((64'sd6240841  * 64'sd65536 + 64'sd50000) / 64'sd100000);
  localparam longint B1 = -((64'sd6887080  * 64'sd65536 + 64'sd50000) / 64'sd100000);
  localparam longint B2 = -((64'sd7975695  * 64'sd65536 + 64'sd50000) / 64'sd100000);
  localparam longint B3 = -((64'sd10995571 * 64'sd65536 + 64'sd50000) / 64'sd100000);
  localparam longint B4 = -((64'sd3799848  * 64'sd65536 + 64'sd50000) / 64'sd100000);

  localparam longint D0 = -((64'sd2041 * 64'sd65536 + 64'sd50000) / 64'sd100000);
  localparam longint D1 = -((64'sd1166 * 64'sd65536 + 64'sd50000) / 64'sd100000);
  localparam longint D2 =  ((64'sd4191 * 64'sd65536 + 64'sd50000) / 64'sd100000);
  localparam longint D3 =  ((64'sd7278 * 64'sd65536 + 64'sd50000) / 64'sd100000);
  localparam longint D4 =  ((64'sd2988 * 64'sd65536 + 64'sd50000) / 64'sd100000);

  localparam longint S0 = ((64'sd666  * 64'sd65536 + 64'sd50000) / 64'sd100000);
  localparam longint S1 = ((64'sd3478 * 64'sd65536 + 64'sd50000) / 64'sd100000);
  localparam longint S2 = ((64'sd2637 * 64'sd65536 + 64'sd50000) / 64'sd100000);
  localparam longint S3 = ((64'sd1773 * 64'sd65536 + 64'sd50000) / 64'sd100000);
  localparam longint S4 = ((64'sd1719 * 64'sd65536 + 64'sd50000) / 64'sd100000);

  localparam longint R0 = ((64'sd1268754 * 64'sd65536 + 64'sd50000) / 64'sd100000);
  localparam longint R1 = ((64'sd353027  * 64'sd65536 + 64'sd50000) / 64'sd100000);
  localparam longint R2 = ((64'sd262230  * 64'sd65536 + 64'sd50000) / 64'sd100000);
  localparam longint R3 = ((64'sd466094  * 64'sd65536 + 64'sd50000) / 64'sd100000);
  localparam longint R4 = ((64'sd274962  * 64'sd65536 + 64'sd50000) / 64'sd100000);

  function automatic logic signed [COEF_W-1:0] lda_bias(input logic [ROW_W-1:0] row);
    logic signed [COEF_W-1:0] c;
    unique case (row)
      ROW_DEEP_WALL: c = COEF_W'(B0);
      ROW_GREEN:     c = COEF_W'(B1);
      ROW_PINK:      c = COEF_W'(B2);
      ROW_RED:       c = COEF_W'(B3);
      ROW_TALL_WALL: c = COEF_W'(B4);
      default:       c = '0;
    endcase
    return c;
  endfunction

  function automatic logic signed [COEF_W-1:0] lda_c_diff(input logic [ROW_W-1:0] row);
    logic signed [COEF_W-1:0] c;
    unique case (row)
      ROW_DEEP_WALL: c = COEF_W'(D0);
      ROW_GREEN:     c = COEF_W'(D1);
      ROW_PINK:      c = COEF_W'(D2);
      ROW_RED:       c = COEF_W'(D3);
      ROW_TALL_WALL: c = COEF_W'(D4);
      default:       c = '0;
    endcase
    return c;
  endfunction

  function automatic logic signed [COEF_W-1:0] lda_c_sum(input logic [ROW_W-1:0] row);
    logic signed [COEF_W-1:0] c;
    unique case (row)
      ROW_DEEP_WALL: c = COEF_W'(S0);
      ROW_GREEN:     c = COEF_W'(S1);
      ROW_PINK:      c = COEF_W'(S2);
      ROW_RED:       c = COEF_W'(S3);
      ROW_TALL_WALL: c = COEF_W'(S4);
      default:       c = '0;
    endcase
    return c;
  endfunction

  function automatic logic signed [COEF_W-1:0] lda_c_ratio(input logic [ROW_W-1:0] row);
    logic signed [COEF_W-1:0] c;
    unique case (row)
      ROW_DEEP_WALL: c = COEF_W'(R0);
      ROW_GREEN:     c = COEF_W'(R1);
      ROW_PINK:      c = COEF_W'(R2);
      ROW_RED:       c = COEF_W'(R3);
      ROW_TALL_WALL: c = COEF_W'(R4);
      default:       c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/rcc_divider.sv =====
// ----------------------------------------------------------------------------
// rcc_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rcc_divider #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] count;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] divisor;
  logic [NUM_W-1:0] shreg;   // dividend bits out at the top, quotient bits in
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem, shreg[NUM_W-1]};
  assign fits  = (trial >= {1'b0, divisor});
  assign quotient = shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else if (start) begin
      count <= CNT_W'(NUM_W);
      done  <= 1'b0;
    end else if (count != '0) begin
      count <= count - CNT_W'(1);
      done  <= (count == CNT_W'(1));
    end else begin
      done  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= '0;
      divisor <= denom;
      shreg   <= numer;
    end else if (count != '0) begin
      if (fits) begin
        rem <= DEN_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[DEN_W-1:0];
      end
      shreg <= {shreg[NUM_W-2:0], fits};
    end
  end

endmodule

// ===== sv/rcc_mac.sv =====
// ----------------------------------------------------------------------------
// rcc_mac
// Shared multiply-accumulate unit: registered product, aligned add into a
// wide accumulator, and truncation toward zero of the final sum.
// ----------------------------------------------------------------------------
module rcc_mac #(
  parameter int ACC_W = 54,
  parameter int FRAC  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  rcc_pkg::rcc_mac_ctrl_t                 ctrl,
  input  logic signed [rcc_pkg::COEF_W-1:0]      coef,
  input  logic signed [rcc_pkg::OP_W-1:0]        operand,
  input  logic signed [ACC_W-1:0]                init,
  output logic signed [ACC_W-rcc_pkg::COEF_FRAC-FRAC-1:0] disc
);

  localparam int PROD_W = rcc_pkg::COEF_W + rcc_pkg::OP_W;
  localparam int RSH    = rcc_pkg::COEF_FRAC + FRAC;

  logic signed [PROD_W-1:0]           prod;
  logic                               pvalid;
  logic [rcc_pkg::SHIFT_W-1:0]        pshamt;
  logic signed [ACC_W-1:0]            acc;
  logic signed [ACC_W-1:0]            addend;
  logic signed [ACC_W-1:0]            biased;

  assign addend = ACC_W'(prod) <<< pshamt;

  // negative sums get 2^RSH-1 added first so the shift truncates toward zero
  assign biased = acc + $signed({{(ACC_W-RSH){1'b0}}, {RSH{acc[ACC_W-1]}}});
  assign disc   = biased[ACC_W-1:RSH];

  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid <= 1'b0;
    end else begin
      pvalid <= ctrl.issue;
    end
  end

  always_ff @(posedge clk) begin
    prod   <= coef * operand;
    pshamt <= ctrl.shamt;
    if (ctrl.clear) begin
      acc <= init;
    end else if (pvalid) begin
      acc <= acc + addend;
    end
  end

endmodule

// ===== sv/reflectance_color_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// reflectance_color_classifier_unit
// Peak/floor tracking of two photodiode channels and a five-discriminant linear
// classifier run on a shared divider and multiply-accumulator.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one sample pair with led_lit and
// window_end per transaction. Items without window_end update the peak and
// floor registers in the accept cycle and produce nothing; they can be sent
// back to back, one per cycle, while no classification is running.
// A window_end item starts the classification: the PREP state registers the
// deltas and starts the restoring divider (one quotient bit per cycle), then
// each of the five discriminants runs through the multiply-accumulator, the
// ratio in NCHUNK = ceil((SAMPLE_BITS+FRACTION_BITS)/17) slices, and the
// DECIDE state loads the result. in_ready is low for that whole run.
// Output channel (out_valid/out_ready): one transaction per window_end item,
// held in an output register. While it waits, new non-end items are still
// taken; a following classification stalls in its last cycle until the
// register is free.
// Reset clears peaks and floors, marks the window as fresh and lit, and
// drops out_valid.
// ----------------------------------------------------------------------------
module reflectance_color_classifier_unit #(
  parameter int SAMPLE_BITS   = 12,
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [SAMPLE_BITS-1:0]        green_sample,
  input  logic [SAMPLE_BITS-1:0]        orange_sample,
  input  logic                          led_lit,
  input  logic                          window_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    object_class,
  output logic signed [SAMPLE_BITS:0]   color_difference,
  output logic [SAMPLE_BITS:0]          color_total
);

  localparam int S         = SAMPLE_BITS;
  localparam int F         = FRACTION_BITS;
  localparam int DELTA_W   = S + 1;
  localparam int SUM_W     = S + 2;
  localparam int QUO_W     = S + F;
  localparam int CHUNK     = rcc_pkg::CHUNK_BITS;
  localparam int NCHUNK    = (QUO_W + CHUNK - 1) / CHUNK;
  localparam int QPAD_W    = NCHUNK * CHUNK;
  localparam int TERM_LAST = rcc_pkg::TERM_RATIO + NCHUNK - 1;
  localparam int TERM_W    = $clog2(TERM_LAST + 1);
  localparam int ACC_W     = S + F + 26;
  localparam int DISC_W    = ACC_W - rcc_pkg::COEF_FRAC - F;
  localparam int ROW_W     = rcc_pkg::ROW_W;

  localparam logic [QUO_W-1:0] RATIO_DEFAULT = QUO_W'(rcc_pkg::RATIO_ZERO_DEN) << F;
  localparam logic signed [SUM_W-1:0] DIFF_MAX = SUM_W'((1 << S) - 1);
  localparam logic signed [SUM_W-1:0] SUM_MAX  = SUM_W'(2 * ((1 << S) - 1));
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(rcc_pkg::ROWS - 1);

  // tracker state
  logic [S-1:0] green_peak, orange_peak, green_floor, orange_floor;
  logic         previous_lit, window_fresh;
  logic [S-1:0] green_peak_next, orange_peak_next, green_floor_next, orange_floor_next;
  logic [S-1:0] green_base, orange_base, green_fl_base, orange_fl_base;

  // sequencer
  rcc_pkg::rcc_state_t state, state_next;
  logic [ROW_W-1:0]  row;
  logic [TERM_W-1:0] term;
  logic [TERM_W-1:0] chunk_idx;
  logic              div_start, div_done, out_load, in_take;

  // window results
  logic signed [DELTA_W-1:0] dg_c, dor_c, dg_abs, dor_abs;
  logic signed [SUM_W-1:0]   diff_r, sum_r;
  logic                      ratio_neg, dg_zero;
  logic [QUO_W-1:0]          div_quotient;
  logic [QUO_W-1:0]          ratio_mag;
  logic [QPAD_W-1:0]         ratio_pad;
  logic signed [DISC_W-1:0]  disc [rcc_pkg::ROWS];
  logic signed [DISC_W-1:0]  mac_disc;

  // mac interface
  rcc_pkg::rcc_mac_ctrl_t               mac_ctrl;
  logic signed [rcc_pkg::COEF_W-1:0]    mac_coef, ratio_coef;
  logic signed [rcc_pkg::OP_W-1:0]      mac_operand;
  logic signed [ACC_W-1:0]              mac_init;

  logic [1:0] class_c;
  logic signed [SUM_W-1:0] diff_sat;
  logic signed [SUM_W-1:0] sum_sat;

  assign in_take = in_valid && in_ready;

  // ---------------- peak / floor tracking ----------------
  assign green_base     = window_fresh ? '0 : green_peak;
  assign orange_base    = window_fresh ? '0 : orange_peak;
  assign green_fl_base  = previous_lit ? green_base  : green_floor;
  assign orange_fl_base = previous_lit ? orange_base : orange_floor;

  always_comb begin
    green_peak_next   = green_base;
    orange_peak_next  = orange_base;
    green_floor_next  = green_floor;
    orange_floor_next = orange_floor;
    if (led_lit) begin
      if (green_sample > green_base)   green_peak_next  = green_sample;
      if (orange_sample > orange_base) orange_peak_next = orange_sample;
    end else begin
      green_floor_next  = (green_sample < green_fl_base) ? green_sample : green_fl_base;
      orange_floor_next = (orange_sample < orange_fl_base) ? orange_sample : orange_fl_base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      green_peak   <= '0;
      orange_peak  <= '0;
      green_floor  <= '0;
      orange_floor <= '0;
      previous_lit <= 1'b1;
      window_fresh <= 1'b1;
    end else if (in_take) begin
      green_peak   <= green_peak_next;
      orange_peak  <= orange_peak_next;
      green_floor  <= green_floor_next;
      orange_floor <= orange_floor_next;
      previous_lit <= window_end ? 1'b1 : led_lit;
      window_fresh <= window_end;
    end
  end

  // ---------------- deltas ----------------
  assign dg_c    = $signed({1'b0, green_peak})  - $signed({1'b0, green_floor});
  assign dor_c   = $signed({1'b0, orange_peak}) - $signed({1'b0, orange_floor});
  assign dg_abs  = dg_c[S]  ? -dg_c  : dg_c;
  assign dor_abs = dor_c[S] ? -dor_c : dor_c;

  always_ff @(posedge clk) begin
    if (state == rcc_pkg::ST_PREP) begin
      diff_r    <= SUM_W'(dor_c) - SUM_W'(dg_c);
      sum_r     <= SUM_W'(dor_c) + SUM_W'(dg_c);
      dg_zero   <= (dg_c == '0);
      ratio_neg <= (dg_c != '0) && (dor_c[S] ^ dg_c[S]);
    end
    if (state == rcc_pkg::ST_DIV && div_done) begin
      ratio_mag <= dg_zero ? RATIO_DEFAULT : div_quotient;
    end
  end

  rcc_divider #(
    .NUM_W(QUO_W),
    .DEN_W(S)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .numer   ({dor_abs[S-1:0], {F{1'b0}}}),
    .denom   (dg_abs[S-1:0]),
    .done    (div_done),
    .quotient(div_quotient)
  );

  // ---------------- discriminant terms ----------------
  assign ratio_pad  = QPAD_W'(ratio_mag);
  assign chunk_idx  = term - TERM_W'(rcc_pkg::TERM_RATIO);
  assign ratio_coef = rcc_pkg::lda_c_ratio(row);
  assign mac_init   = ACC_W'(rcc_pkg::lda_bias(row)) <<< F;

  always_comb begin
    mac_coef    = ratio_neg ? -ratio_coef : ratio_coef;
    mac_operand = $signed({1'b0, ratio_pad[chunk_idx*CHUNK +: CHUNK]});
    mac_ctrl.shamt = rcc_pkg::SHIFT_W'(chunk_idx * CHUNK);
    case (term)
      TERM_W'(rcc_pkg::TERM_DIFF): begin
        mac_coef       = rcc_pkg::lda_c_diff(row);
        mac_operand    = rcc_pkg::OP_W'(diff_r);
        mac_ctrl.shamt = rcc_pkg::SHIFT_W'(F);
      end
      TERM_W'(rcc_pkg::TERM_SUM): begin
        mac_coef       = rcc_pkg::lda_c_sum(row);
        mac_operand    = rcc_pkg::OP_W'(sum_r);
        mac_ctrl.shamt = rcc_pkg::SHIFT_W'(F);
      end
      default: ;
    endcase
    mac_ctrl.clear = (state == rcc_pkg::ST_MAC) && (term == TERM_W'(rcc_pkg::TERM_INIT));
    mac_ctrl.issue = (state == rcc_pkg::ST_MAC) && (term != TERM_W'(rcc_pkg::TERM_INIT));
  end

  rcc_mac #(
    .ACC_W(ACC_W),
    .FRAC (F)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .coef   (mac_coef),
    .operand(mac_operand),
    .init   (mac_init),
    .disc   (mac_disc)
  );

  always_ff @(posedge clk) begin
    if (state == rcc_pkg::ST_STORE) begin
      disc[row] <= mac_disc;
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rcc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      rcc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && window_end) state_next = rcc_pkg::ST_PREP;
      end
      rcc_pkg::ST_PREP: begin
        div_start  = 1'b1;
        state_next = rcc_pkg::ST_DIV;
      end
      rcc_pkg::ST_DIV: begin
        if (div_done) state_next = rcc_pkg::ST_MAC;
      end
      rcc_pkg::ST_MAC: begin
        if (term == TERM_W'(TERM_LAST)) state_next = rcc_pkg::ST_DRAIN;
      end
      rcc_pkg::ST_DRAIN: begin
        state_next = rcc_pkg::ST_STORE;
      end
      rcc_pkg::ST_STORE: begin
        state_next = (row == ROW_LAST) ? rcc_pkg::ST_DECIDE : rcc_pkg::ST_MAC;
      end
      rcc_pkg::ST_DECIDE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = rcc_pkg::ST_IDLE;
        end
      end
      default: state_next = rcc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row  <= '0;
      term <= '0;
    end else begin
      case (state)
        rcc_pkg::ST_DIV: begin
          row  <= '0;
          term <= '0;
        end
        rcc_pkg::ST_MAC:   term <= term + TERM_W'(1);
        rcc_pkg::ST_STORE: begin
          row  <= row + ROW_W'(1);
          term <= '0;
        end
        default: ;
      endcase
    end
  end

  // ---------------- decision and output register ----------------
  always_comb begin
    if ((disc[0] > disc[1] && disc[0] > disc[2] && disc[0] > disc[3]) ||
        (disc[4] > disc[1] && disc[4] > disc[2] && disc[4] > disc[3])) begin
      class_c = rcc_pkg::CLASS_WALL;
    end else if (disc[1] > disc[2] && disc[1] > disc[3]) begin
      class_c = rcc_pkg::CLASS_GREEN;
    end else if (disc[2] > disc[1] && disc[2] > disc[3]) begin
      class_c = rcc_pkg::CLASS_PINK;
    end else begin
      class_c = rcc_pkg::CLASS_RED;
    end
  end

  always_comb begin
    diff_sat = diff_r;
    if (diff_r > DIFF_MAX)  diff_sat = DIFF_MAX;
    if (diff_r < -DIFF_MAX) diff_sat = -DIFF_MAX;
    sum_sat = sum_r;
    if (sum_r < 0)        sum_sat = '0;
    if (sum_r > SUM_MAX)  sum_sat = SUM_MAX;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      object_class     <= class_c;
      color_difference <= diff_sat[S:0];
      color_total      <= sum_sat[S:0];
    end
  end

endmodule

// ===== sv/rcc_checker.sv =====
// ----------------------------------------------------------------------------
// rcc_checker
// Port-level checks for the reflectance color classifier, bound to the top.
// ----------------------------------------------------------------------------
module rcc_checker #(
  parameter int SAMPLE_BITS = 12
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        window_end,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  object_class,
  input logic signed [SAMPLE_BITS:0] color_difference,
  input logic [SAMPLE_BITS:0]        color_total
);

  localparam logic [SAMPLE_BITS:0] TOTAL_MAX = {{SAMPLE_BITS{1'b1}}, 1'b0};
  localparam logic [SAMPLE_BITS:0] DIFF_BAD  = {1'b1, {SAMPLE_BITS{1'b0}}};

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(object_class) &&
      $stable(color_difference) && $stable(color_total))
    else $error("result changed while stalled");

  // a window end starts the classifier, which blocks the input
  a_busy_after_end: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && window_end |=> !in_ready)
    else $error("input taken during classification");

  // saturated outputs stay inside their ranges
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> color_total <= TOTAL_MAX && color_difference != $signed(DIFF_BAD))
    else $error("output out of saturation range");

  // a new result only appears out of a classification run
  a_rose_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without classification");

endmodule

bind reflectance_color_classifier_unit rcc_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_rcc_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .window_end      (window_end),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .object_class    (object_class),
  .color_difference(color_difference),
  .color_total     (color_total)
);
